// File: design/sort_and_count_distinct_unit_macros.svh
// Assertion macros for the sort and count unit
`ifndef SORT_AND_COUNT_DISTINCT_UNIT_MACROS_SVH
`define SORT_AND_COUNT_DISTINCT_UNIT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define SCD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication outside reset
`define SCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/scd_pkg.sv
package scd_pkg;

    localparam int SCD_MAX_ITEMS = 1024;
    localparam int SCD_VALUE_W   = 32;
    localparam int SCD_COUNT_W   = 11;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_PAIR  = 4'b0010,
        ST_MERGE = 4'b0100,
        ST_COUNT = 4'b1000
    } scd_state_t;

endpackage

// File: design/sort_and_count_distinct_unit.sv
// Sort and count distinct unit. Takes a set of signed 32-bit values, one
// beat per cycle on the s_ channel with the final beat marked by s_is_last,
// and returns one beat on the m_ channel: the number of distinct values and
// an overflow flag set when more than MAX_ITEMS values arrived (the extra
// ones are dropped). Loading runs at one beat a cycle. After the last beat
// the set is sorted by a bottom-up merge sort that ping-pongs between two
// memories, one entry written per cycle: ceil(log2(n)) merge passes, with a
// set-up step (ST_PAIR) before each pair of runs, then a counting pass. s_ready
// stays low while a set is being sorted and counted; the result is held in
// an output register, so loading of the next set may begin while it waits
// to be taken.
module sort_and_count_distinct_unit
    import scd_pkg::*;
#(
    parameter int MAX_ITEMS = SCD_MAX_ITEMS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SCD_VALUE_W-1:0] s_value,
    input  logic                          s_is_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic        [SCD_COUNT_W-1:0] m_distinct_count,
    output logic                          m_overflow
);

`include "sort_and_count_distinct_unit_macros.svh"

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    // wide enough for base + 2 * width during a pass
    localparam int CW = $clog2(MAX_ITEMS + 1) + 2;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // two ping-pong stores
    logic signed [SCD_VALUE_W-1:0] mem_a [MAX_ITEMS];
    logic signed [SCD_VALUE_W-1:0] mem_b [MAX_ITEMS];

    logic signed [SCD_VALUE_W-1:0] rd_a_l_reg, rd_a_r_reg, rd_b_l_reg, rd_b_r_reg;

    scd_state_t state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic          ovf_reg, ovf_next;
    logic          src_reg, src_next;   // 0: mem_a holds the runs
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] base_reg, base_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] q_reg, q_next;
    logic [CW-1:0] pend_reg, pend_next;
    logic [CW-1:0] qend_reg, qend_next;
    logic [CW-1:0] o_reg, o_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic signed [SCD_VALUE_W-1:0] prev_reg, prev_next;
    logic          mv_reg, mv_next;
    logic [SCD_COUNT_W-1:0] mcnt_reg, mcnt_next;
    logic          movf_reg, movf_next;

    logic signed [SCD_VALUE_W-1:0] dl, dq, wd;
    logic          wr_a, wr_b;
    logic [CW-1:0] wa;
    logic [CW-1:0] sum_w, sum_2w, w2;
    logic          left_ok, right_ok, take_left;
    logic          s_acc;

    assign dl = src_reg ? rd_b_l_reg : rd_a_l_reg;
    assign dq = src_reg ? rd_b_r_reg : rd_a_r_reg;
    assign s_ready = (state_reg == ST_LOAD);
    assign s_acc   = s_valid && s_ready;

    assign sum_w  = base_reg + w_reg;
    assign sum_2w = base_reg + (w_reg << 1);
    assign w2     = w_reg << 1;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        src_next   = src_reg;
        w_next     = w_reg;
        base_next  = base_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        pend_next  = pend_reg;
        qend_next  = qend_reg;
        o_next     = o_reg;
        cnt_next   = cnt_reg;
        prev_next  = prev_reg;
        mv_next    = mv_reg && !m_ready;
        mcnt_next  = mcnt_reg;
        movf_next  = movf_reg;
        wr_a       = 1'b0;
        wr_b       = 1'b0;
        wa         = n_reg;
        wd         = s_value;
        left_ok    = (p_reg < pend_reg);
        right_ok   = (q_reg < qend_reg);
        take_left  = left_ok && (!right_ok || (dl <= dq));

        case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (n_reg < MAX_C) begin
                        wr_a   = 1'b1;
                        n_next = n_reg + ONE_C;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_is_last) begin
                        src_next  = 1'b0;
                        w_next    = ONE_C;
                        base_next = '0;
                        if (n_next <= ONE_C) begin
                            state_next = ST_COUNT;
                            p_next     = '0;
                            cnt_next   = '0;
                        end else begin
                            state_next = ST_PAIR;
                        end
                    end
                end
            end
            ST_PAIR: begin
                // set up the next pair of runs and fetch both heads
                pend_next  = (sum_w < n_reg) ? sum_w : n_reg;
                qend_next  = (sum_2w < n_reg) ? sum_2w : n_reg;
                p_next     = base_reg;
                q_next     = pend_next;
                o_next     = base_reg;
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                wa = o_reg;
                wd = take_left ? dl : dq;
                wr_a = src_reg;
                wr_b = !src_reg;
                o_next = o_reg + ONE_C;
                if (take_left) begin
                    p_next = p_reg + ONE_C;
                end else begin
                    q_next = q_reg + ONE_C;
                end
                if (o_next == qend_reg) begin
                    base_next = sum_2w;
                    state_next = ST_PAIR;
                    if (sum_2w >= n_reg) begin
                        // pass done: flip the stores and double the run width
                        src_next  = !src_reg;
                        w_next    = w2;
                        base_next = '0;
                        if (w2 >= n_reg) begin
                            state_next = ST_COUNT;
                            p_next     = '0;
                            cnt_next   = '0;
                        end
                    end
                end
            end
            ST_COUNT: begin
                if (p_reg < n_reg) begin
                    if ((p_reg == '0) || (dl != prev_reg)) begin
                        cnt_next = cnt_reg + ONE_C;
                    end
                    prev_next = dl;
                    p_next    = p_reg + ONE_C;
                end else if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mcnt_next  = SCD_COUNT_W'(cnt_reg);
                    movf_next  = ovf_reg;
                    n_next     = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // stores: one write and two registered reads each
    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[wa[AW-1:0]] <= wd;
        end
        if (wr_b) begin
            mem_b[wa[AW-1:0]] <= wd;
        end
        rd_a_l_reg <= mem_a[p_next[AW-1:0]];
        rd_a_r_reg <= mem_a[q_next[AW-1:0]];
        rd_b_l_reg <= mem_b[p_next[AW-1:0]];
        rd_b_r_reg <= mem_b[q_next[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            mv_reg    <= 1'b0;
            src_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
            mv_reg    <= mv_next;
            src_reg   <= src_next;
        end
        w_reg    <= w_next;
        base_reg <= base_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        pend_reg <= pend_next;
        qend_reg <= qend_next;
        o_reg    <= o_next;
        cnt_reg  <= cnt_next;
        prev_reg <= prev_next;
        mcnt_reg <= mcnt_next;
        movf_reg <= movf_next;
    end

    assign m_valid          = mv_reg;
    assign m_distinct_count = mcnt_reg;
    assign m_overflow       = movf_reg;

    `SCD_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, n_reg <= MAX_C, "store overfilled")
    `SCD_ASSERT_IMPL(a_merge_in_pair, aclk, aresetn, state_reg == ST_MERGE, (o_reg < qend_reg) && (left_ok || right_ok), "merge ran past its pair")
    `SCD_ASSERT_NEXT(a_result_starts_load, aclk, aresetn, mv_reg == 1'b0 && mv_next == 1'b1, state_reg == ST_LOAD && n_reg == '0, "result without clearing the set")

endmodule
